// ===== src/scl_pkg.sv =====
// shared types, codes and constants of the serial command line parser
package scl_pkg;

	// line storage limit and the width of the length counter
	localparam int unsigned LineCapacity = 32;
	localparam int unsigned LenW = $clog2(LineCapacity);

	// character codes
	localparam logic [7:0] CharNul   = 8'h00;
	localparam logic [7:0] CharTab   = 8'h09;
	localparam logic [7:0] CharLf    = 8'h0A;
	localparam logic [7:0] CharVt    = 8'h0B;
	localparam logic [7:0] CharFf    = 8'h0C;
	localparam logic [7:0] CharCr    = 8'h0D;
	localparam logic [7:0] CharSpace = 8'h20;
	localparam logic [7:0] CharPlus  = 8'h2B;
	localparam logic [7:0] CharMinus = 8'h2D;
	localparam logic [7:0] CharZero  = 8'h30;
	localparam logic [7:0] CharNine  = 8'h39;
	localparam logic [7:0] CharColon = 8'h3A;
	localparam logic [7:0] CharE     = 8'h45;
	localparam logic [7:0] CharG     = 8'h47;
	localparam logic [7:0] CharI     = 8'h49;
	localparam logic [7:0] CharN     = 8'h4E;
	localparam logic [7:0] CharP     = 8'h50;
	localparam logic [7:0] CharQ     = 8'h51;
	localparam logic [7:0] CharR     = 8'h52;

	// item kinds on the input channel
	localparam logic KindByte = 1'b0;
	localparam logic KindTick = 1'b1;

	// register map
	localparam int unsigned PaddrW = 2;
	localparam logic [PaddrW-1:0] AddrStallLimit = 2'd0;
	localparam logic [7:0] StallLimitReset = 8'd20;

	// result command codes
	typedef enum logic [1:0] {
		CMD_UNKNOWN  = 2'd0,
		CMD_DATA_REQ = 2'd1,
		CMD_PING     = 2'd2
	} cmd_t;

	// line match progress, one-hot
	typedef enum logic [13:0] {
		MP_START     = 14'h0001,
		MP_R         = 14'h0002,
		MP_RE        = 14'h0004,
		MP_REQ       = 14'h0008,
		MP_REQ_COLON = 14'h0010,
		MP_P         = 14'h0020,
		MP_PI        = 14'h0040,
		MP_PIN       = 14'h0080,
		MP_PING      = 14'h0100,
		MP_LEAD      = 14'h0200,
		MP_SIGN      = 14'h0400,
		MP_DIGITS    = 14'h0800,
		MP_AFTER     = 14'h1000,
		MP_REJECT    = 14'h2000
	} mp_t;

	// per-line match and number state
	typedef struct packed {
		mp_t         mp;
		logic        text_ended;
		logic        negative;
		logic        digits_seen;
		logic [31:0] value;
		logic        saturated;
	} match_state_t;

	localparam match_state_t MatchClear = '{
		mp: MP_START, text_ended: 1'b0, negative: 1'b0,
		digits_seen: 1'b0, value: 32'd0, saturated: 1'b0
	};

endpackage

// ===== src/scl_if.sv =====
// channel interfaces of the serial command line parser

// received byte or tick
interface scl_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink (input valid, input kind, input data_byte, output ready);
endinterface

// parsed line result
interface scl_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [31:0] ping_sequence;

	modport source (output valid, output command, output ping_sequence, input ready);
	modport sink (input valid, input command, input ping_sequence, output ready);
endinterface

// ===== src/scl_match.sv =====
// incremental matcher: advances the line match state by one text byte
module scl_match (
	input  logic [7:0]                 byte_in,
	input  scl_pkg::match_state_t      st,
	output scl_pkg::match_state_t      st_next
);

	logic        is_digit;
	logic [3:0]  digit;
	logic [35:0] acc;
	logic        ovf;
	logic        do_add;

	// value * 10 + digit as two shifted adds, overflow past 32 bits saturates
	assign is_digit = (byte_in >= scl_pkg::CharZero) && (byte_in <= scl_pkg::CharNine);
	assign digit    = 4'(byte_in - scl_pkg::CharZero);
	assign acc      = ({4'd0, st.value} << 3) + ({4'd0, st.value} << 1) + {32'd0, digit};
	assign ovf      = (acc[35:32] != 4'd0);

	// next match state
	always_comb begin
		st_next = st;
		do_add  = 1'b0;
		if (!st.text_ended) begin
			if (byte_in == scl_pkg::CharNul) begin
				st_next.text_ended = 1'b1;
			end else begin
				unique case (st.mp)
					scl_pkg::MP_START: begin
						if (byte_in == scl_pkg::CharR)
							st_next.mp = scl_pkg::MP_R;
						else if (byte_in == scl_pkg::CharP)
							st_next.mp = scl_pkg::MP_P;
						else
							st_next.mp = scl_pkg::MP_REJECT;
					end
					scl_pkg::MP_R: st_next.mp = (byte_in == scl_pkg::CharE) ?
						scl_pkg::MP_RE : scl_pkg::MP_REJECT;
					scl_pkg::MP_RE: st_next.mp = (byte_in == scl_pkg::CharQ) ?
						scl_pkg::MP_REQ : scl_pkg::MP_REJECT;
					scl_pkg::MP_REQ: st_next.mp = (byte_in == scl_pkg::CharColon) ?
						scl_pkg::MP_REQ_COLON : scl_pkg::MP_REJECT;
					scl_pkg::MP_P: st_next.mp = (byte_in == scl_pkg::CharI) ?
						scl_pkg::MP_PI : scl_pkg::MP_REJECT;
					scl_pkg::MP_PI: st_next.mp = (byte_in == scl_pkg::CharN) ?
						scl_pkg::MP_PIN : scl_pkg::MP_REJECT;
					scl_pkg::MP_PIN: st_next.mp = (byte_in == scl_pkg::CharG) ?
						scl_pkg::MP_PING : scl_pkg::MP_REJECT;
					scl_pkg::MP_PING: st_next.mp = (byte_in == scl_pkg::CharColon) ?
						scl_pkg::MP_LEAD : scl_pkg::MP_REJECT;
					scl_pkg::MP_LEAD: begin
						if (byte_in == scl_pkg::CharSpace || byte_in == scl_pkg::CharTab ||
								byte_in == scl_pkg::CharVt || byte_in == scl_pkg::CharFf) begin
							st_next.mp = scl_pkg::MP_LEAD;
						end else if (byte_in == scl_pkg::CharPlus) begin
							st_next.mp = scl_pkg::MP_SIGN;
						end else if (byte_in == scl_pkg::CharMinus) begin
							st_next.negative = 1'b1;
							st_next.mp       = scl_pkg::MP_SIGN;
						end else if (is_digit) begin
							do_add     = 1'b1;
							st_next.mp = scl_pkg::MP_DIGITS;
						end else begin
							st_next.mp = scl_pkg::MP_REJECT;
						end
					end
					scl_pkg::MP_SIGN: begin
						if (is_digit) begin
							do_add     = 1'b1;
							st_next.mp = scl_pkg::MP_DIGITS;
						end else begin
							st_next.mp = scl_pkg::MP_REJECT;
						end
					end
					scl_pkg::MP_DIGITS: begin
						if (is_digit)
							do_add = 1'b1;
						else
							st_next.mp = scl_pkg::MP_AFTER;
					end
					default: st_next.mp = st.mp;
				endcase
			end
		end
		// digit accumulation
		if (do_add) begin
			st_next.digits_seen = 1'b1;
			if (!st.saturated) begin
				if (ovf)
					st_next.saturated = 1'b1;
				else
					st_next.value = acc[31:0];
			end
		end
	end

endmodule

// ===== src/serial_command_line_parser.sv =====
// top level of the serial command line parser
//
//  channel   dir  transfer        payload
//  in_item   in   valid & ready   kind, data_byte
//  result    out  valid & ready   command, ping_sequence
//  apb       in   psel&penable    paddr, pwdata, prdata (stall_limit_ticks at 0x0)
//
// one item per cycle sustained while results are taken; an item is registered
// in the input register on transfer, and its line state and any result are
// registered when it leaves that register. arst_n clears the line state, the
// idle count and the output register and loads the stall limit with 20. when
// a result waits untaken, no item leaves the input register, and once that
// register holds an item in_item.ready drops until the result moves.
module serial_command_line_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	scl_in_if.sink                        in_item,
	scl_out_if.source                     result,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [scl_pkg::PaddrW-1:0]    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	localparam int unsigned LenW = scl_pkg::LenW;
	localparam logic [LenW-1:0] LenLast = LenW'(scl_pkg::LineCapacity - 1);

	logic                    valid_s1;
	logic                    kind_s1;
	logic [7:0]              byte_s1;
	logic                    advance;

	logic [7:0]              stall_limit_q;
	logic [7:0]              idle_q;
	logic [LenW-1:0]         len_q;
	scl_pkg::match_state_t   st_q;

	logic [7:0]              idle_inc;
	logic [7:0]              idle_chk;
	logic                    stalled;
	scl_pkg::match_state_t   st_live;
	scl_pkg::match_state_t   st_match;
	logic [LenW-1:0]         len_live;

	logic [7:0]              idle_d;
	logic [LenW-1:0]         len_d;
	scl_pkg::match_state_t   st_d;
	logic                    res_fire;
	scl_pkg::cmd_t           res_cmd;
	logic [31:0]             res_seq;

	logic                    out_valid_q;
	scl_pkg::cmd_t           out_cmd_q;
	logic [31:0]             out_seq_q;

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr == scl_pkg::AddrStallLimit) ? {24'd0, stall_limit_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stall_limit_q <= scl_pkg::StallLimitReset;
		end else if (psel && penable && pwrite && paddr == scl_pkg::AddrStallLimit) begin
			stall_limit_q <= pwdata[7:0];
		end
	end

	// input register
	assign advance       = valid_s1 && (!out_valid_q || result.ready);
	assign in_item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_item.ready) begin
			valid_s1 <= in_item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_item.valid && in_item.ready) begin
			kind_s1 <= in_item.kind;
			byte_s1 <= in_item.data_byte;
		end
	end

	// stall check: ticks look at the bumped count, bytes at the count so far
	assign idle_inc = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;
	assign idle_chk = (kind_s1 == scl_pkg::KindTick) ? idle_inc : idle_q;
	assign stalled  = (len_q != '0) && (idle_chk > stall_limit_q);
	assign st_live  = stalled ? scl_pkg::MatchClear : st_q;
	assign len_live = stalled ? '0 : len_q;

	scl_match u_match (
		.byte_in (byte_s1),
		.st      (st_live),
		.st_next (st_match)
	);

	// line state update and result decode
	always_comb begin
		idle_d   = idle_q;
		len_d    = len_live;
		st_d     = st_live;
		res_fire = 1'b0;
		res_cmd  = scl_pkg::CMD_UNKNOWN;
		res_seq  = 32'd0;
		if (kind_s1 == scl_pkg::KindTick) begin
			idle_d = idle_inc;
		end else begin
			idle_d = 8'd0;
			if (byte_s1 == scl_pkg::CharCr) begin
				len_d = len_live;
			end else if (byte_s1 == scl_pkg::CharLf) begin
				res_fire = 1'b1;
				unique case (st_live.mp) inside
					scl_pkg::MP_REQ, scl_pkg::MP_REQ_COLON: res_cmd = scl_pkg::CMD_DATA_REQ;
					scl_pkg::MP_PING: res_cmd = scl_pkg::CMD_PING;
					scl_pkg::MP_DIGITS, scl_pkg::MP_AFTER: begin
						res_cmd = scl_pkg::CMD_PING;
						if (st_live.saturated)
							res_seq = 32'hFFFF_FFFF;
						else if (st_live.negative)
							res_seq = 32'd0 - st_live.value;
						else
							res_seq = st_live.value;
					end
					default: res_cmd = scl_pkg::CMD_UNKNOWN;
				endcase
				len_d = '0;
				st_d  = scl_pkg::MatchClear;
			end else if (len_live < LenLast) begin
				len_d = len_live + 1'b1;
				st_d  = st_match;
			end else begin
				len_d = '0;
				st_d  = scl_pkg::MatchClear;
			end
		end
	end

	// line state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_q <= 8'd0;
			len_q  <= '0;
			st_q   <= scl_pkg::MatchClear;
		end else if (advance) begin
			idle_q <= idle_d;
			len_q  <= len_d;
			st_q   <= st_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= res_fire;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_fire) begin
			out_cmd_q <= res_cmd;
			out_seq_q <= res_seq;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.command       = out_cmd_q;
	assign result.ping_sequence = out_seq_q;

	// checks
	a_match_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(st_q.mp))
		else $error("match progress lost its one-hot code");

	a_seq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_cmd_q != scl_pkg::CMD_PING |-> out_seq_q == 32'd0)
		else $error("non-ping result carries a sequence");

	a_byte_clears_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == scl_pkg::KindByte |=> idle_q == 8'd0)
		else $error("received byte did not clear the idle count");

	a_lf_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance && kind_s1 == scl_pkg::KindByte && byte_s1 == scl_pkg::CharLf
		|=> out_valid_q && len_q == '0)
		else $error("line end gave no result or kept the line");

endmodule
